FILE: rtl/core/ccdq_pkg.sv
// Shared types, constants and operation codes of the capsule chain distance query.
// Used by the controller, the datapath, the top level and the port checker.
package ccdq_pkg;

   localparam int MaxNodes   = 64;
   localparam int AddrW      = 6;
   localparam int HDivSteps  = 16;
   localparam int SqrtSteps  = 36;
   localparam int GDivSteps  = 16;

   // Input opcodes.
   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OUTER_COUNT = 3'd0;
   localparam logic [2:0] CSR_INNER_COUNT = 3'd1;
   localparam logic [2:0] CSR_TOOL_COUNT  = 3'd2;
   localparam logic [2:0] CSR_TOOL_PRES   = 3'd3;
   localparam logic [2:0] CSR_OUTER_RAD   = 3'd4;
   localparam logic [2:0] CSR_INNER_RAD   = 3'd5;
   localparam logic [2:0] CSR_TOOL_RAD    = 3'd6;

   // Segment groups in search order.
   localparam logic [1:0] GRP_TOOL  = 2'd0;
   localparam logic [1:0] GRP_INNER = 2'd1;
   localparam logic [1:0] GRP_OUTER = 2'd2;
   localparam logic [1:0] GRP_DONE  = 2'd3;

   // Datapath operations.
   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_WRITE   = 5'd1;
   localparam logic [4:0] OP_START   = 5'd2;
   localparam logic [4:0] OP_READ    = 5'd3;
   localparam logic [4:0] OP_DIFF    = 5'd4;
   localparam logic [4:0] OP_MUL_DOT = 5'd5;
   localparam logic [4:0] OP_MUL_LEN = 5'd6;
   localparam logic [4:0] OP_ACC_DOT = 5'd7;
   localparam logic [4:0] OP_ACC_LEN = 5'd8;
   localparam logic [4:0] OP_HCHK    = 5'd9;
   localparam logic [4:0] OP_HDIV    = 5'd10;
   localparam logic [4:0] OP_MUL_T   = 5'd11;
   localparam logic [4:0] OP_VSET    = 5'd12;
   localparam logic [4:0] OP_MUL_V   = 5'd13;
   localparam logic [4:0] OP_ACC_VV  = 5'd14;
   localparam logic [4:0] OP_SQ_INIT = 5'd15;
   localparam logic [4:0] OP_SQ_STEP = 5'd16;
   localparam logic [4:0] OP_DIST    = 5'd17;
   localparam logic [4:0] OP_G_INIT  = 5'd18;
   localparam logic [4:0] OP_G_STEP  = 5'd19;
   localparam logic [4:0] OP_G_SET   = 5'd20;
   localparam logic [4:0] OP_CMP     = 5'd21;

   typedef struct packed {
      logic               opcode;
      logic [5:0]         write_slot;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic               tool_search_only;
   } req_type;

   typedef struct packed {
      logic signed [31:0] distance;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic signed [15:0] grad_z;
      logic [5:0]         nearest_node;
      logic [16:0]        seg_fraction;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  outer_node_count;
      logic [6:0]  inner_node_count;
      logic [6:0]  tool_node_count;
      logic        tool_present;
      logic [30:0] outer_radius;
      logic [30:0] inner_radius;
      logic [30:0] tool_radius;
   } cfg_type;

   typedef struct packed {
      logic [4:0]       op;
      logic [1:0]       sel;
      logic [AddrW-1:0] addr;
      logic [1:0]       grp;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic best_neg;
   } sts_type;

endpackage

FILE: rtl/core/capsule_chain_distance_query.sv
// Top level of the capsule chain distance query: configuration registers,
// controller and datapath. Depends on ccdq_pkg, ccdq_ctrl and ccdq_datapath.
//
// Usage: a transaction is taken on req_payload at a rising edge with start high
// and busy low. A node write (opcode 0) completes in that cycle and busy stays
// low. A query (opcode 1) raises busy and walks the capsules tool, inner, outer,
// stopping early once the best distance is negative.
// Each capsule runs the interpolation division only when its factor falls
// strictly between 0 and 1; the 36-step square root and the three 16-step
// gradient divisions run on the shared serial units. The result appears on
// rsp_payload for exactly one cycle with rsp_valid high, in the cycle before
// busy falls; the receiver cannot stall it. Configuration is a plain write port
// (csr_we, csr_index, csr_wdata) taken at any edge with csr_we high; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset is synchronous: it clears the configuration and returns the controller
// to idle. Node store contents are undefined until written.
module capsule_chain_distance_query (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ccdq_pkg::req_type req_payload,
   output logic              busy,
   output logic              rsp_valid,
   output ccdq_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [30:0]       csr_wdata
);

   ccdq_pkg::cfg_type cfg_ff, cfg_in;
   ccdq_pkg::cmd_type cmd;
   ccdq_pkg::sts_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ccdq_pkg::CSR_OUTER_COUNT: cfg_in.outer_node_count = csr_wdata[6:0];
            ccdq_pkg::CSR_INNER_COUNT: cfg_in.inner_node_count = csr_wdata[6:0];
            ccdq_pkg::CSR_TOOL_COUNT:  cfg_in.tool_node_count  = csr_wdata[6:0];
            ccdq_pkg::CSR_TOOL_PRES:   cfg_in.tool_present     = csr_wdata[0];
            ccdq_pkg::CSR_OUTER_RAD:   cfg_in.outer_radius     = csr_wdata;
            ccdq_pkg::CSR_INNER_RAD:   cfg_in.inner_radius     = csr_wdata;
            ccdq_pkg::CSR_TOOL_RAD:    cfg_in.tool_radius      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_payload),
      .cfg       (cfg_ff),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ccdq_datapath u_datapath (
      .clock (clock),
      .cmd   (cmd),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .sts   (sts),
      .rsp   (rsp_payload)
   );

endmodule

FILE: rtl/core/ccdq_ctrl.sv
// Controller of the capsule chain distance query: walks groups and segments and
// sequences the datapath one operation per cycle. Depends on ccdq_pkg.
module ccdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ccdq_pkg::req_type req,
   input  ccdq_pkg::cfg_type cfg,
   input  ccdq_pkg::sts_type sts,
   output ccdq_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_valid
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_SEG  = 5'd1;
   localparam logic [4:0] S_RDA  = 5'd2;
   localparam logic [4:0] S_RDB  = 5'd3;
   localparam logic [4:0] S_DIFF = 5'd4;
   localparam logic [4:0] S_DOTM = 5'd5;
   localparam logic [4:0] S_DOTA = 5'd6;
   localparam logic [4:0] S_LENM = 5'd7;
   localparam logic [4:0] S_LENA = 5'd8;
   localparam logic [4:0] S_HCHK = 5'd9;
   localparam logic [4:0] S_HDIV = 5'd10;
   localparam logic [4:0] S_TM   = 5'd11;
   localparam logic [4:0] S_TV   = 5'd12;
   localparam logic [4:0] S_VM   = 5'd13;
   localparam logic [4:0] S_VA   = 5'd14;
   localparam logic [4:0] S_SQI  = 5'd15;
   localparam logic [4:0] S_SQ   = 5'd16;
   localparam logic [4:0] S_DIST = 5'd17;
   localparam logic [4:0] S_GI   = 5'd18;
   localparam logic [4:0] S_GD   = 5'd19;
   localparam logic [4:0] S_GS   = 5'd20;
   localparam logic [4:0] S_CMP  = 5'd21;
   localparam logic [4:0] S_NEXT = 5'd22;
   localparam logic [4:0] S_OUT  = 5'd23;

   logic [4:0] state_ff, state_in;
   logic [1:0] grp_ff, grp_in;
   logic [6:0] idx_ff, idx_in;
   logic [1:0] sel_ff, sel_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       only_ff, only_in;

   logic [8:0] base;
   logic [8:0] count;
   logic [8:0] seg_end;
   logic       seg_ok;
   logic [1:0] grp_after;
   logic [1:0] grp_first;
   logic [ccdq_pkg::AddrW-1:0] addr_a;

   always_comb begin
      unique case (grp_ff)
         ccdq_pkg::GRP_TOOL: begin
            base  = 9'(cfg.outer_node_count) + 9'(cfg.inner_node_count);
            count = 9'(cfg.tool_node_count);
         end
         ccdq_pkg::GRP_INNER: begin
            base  = 9'(cfg.outer_node_count);
            count = 9'(cfg.inner_node_count);
         end
         ccdq_pkg::GRP_OUTER: begin
            base  = 9'd0;
            count = 9'(cfg.outer_node_count);
         end
         default: begin
            base  = 9'd0;
            count = 9'd0;
         end
      endcase
      // A segment exists while its end node lies in the group and in the store.
      seg_end = base + 9'(idx_ff) + 9'd1;
      seg_ok  = (9'(idx_ff) + 9'd1 < count) && (seg_end < 9'(ccdq_pkg::MaxNodes));
      addr_a  = ccdq_pkg::AddrW'(base + 9'(idx_ff));

      unique case (grp_ff)
         ccdq_pkg::GRP_TOOL:  grp_after = only_ff ? ccdq_pkg::GRP_DONE : ccdq_pkg::GRP_INNER;
         ccdq_pkg::GRP_INNER: grp_after = ccdq_pkg::GRP_OUTER;
         default:             grp_after = ccdq_pkg::GRP_DONE;
      endcase
      if (cfg.tool_present) begin
         grp_first = ccdq_pkg::GRP_TOOL;
      end else begin
         grp_first = req.tool_search_only ? ccdq_pkg::GRP_DONE : ccdq_pkg::GRP_INNER;
      end
   end

   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      only_in  = only_ff;
      cmd.op   = ccdq_pkg::OP_NOP;
      cmd.sel  = sel_ff;
      cmd.addr = addr_a;
      cmd.grp  = grp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req.opcode == ccdq_pkg::OPC_WRITE) begin
                  cmd.op = ccdq_pkg::OP_WRITE;
               end else begin
                  cmd.op   = ccdq_pkg::OP_START;
                  grp_in   = grp_first;
                  only_in  = req.tool_search_only;
                  idx_in   = 7'd0;
                  state_in = S_SEG;
               end
            end
         end
         S_SEG: begin
            if (grp_ff == ccdq_pkg::GRP_DONE) begin
               state_in = S_OUT;
            end else if (seg_ok) begin
               state_in = S_RDA;
            end else begin
               grp_in = grp_after;
               idx_in = 7'd0;
            end
         end
         S_RDA: begin
            cmd.op   = ccdq_pkg::OP_READ;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op   = ccdq_pkg::OP_READ;
            cmd.addr = addr_a + ccdq_pkg::AddrW'(1);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = ccdq_pkg::OP_DIFF;
            sel_in   = 2'd0;
            state_in = S_DOTM;
         end
         S_DOTM: begin
            cmd.op   = ccdq_pkg::OP_MUL_DOT;
            state_in = S_DOTA;
         end
         S_DOTA: begin
            cmd.op = ccdq_pkg::OP_ACC_DOT;
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = S_LENM;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_DOTM;
            end
         end
         S_LENM: begin
            cmd.op   = ccdq_pkg::OP_MUL_LEN;
            state_in = S_LENA;
         end
         S_LENA: begin
            cmd.op = ccdq_pkg::OP_ACC_LEN;
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = S_HCHK;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_LENM;
            end
         end
         S_HCHK: begin
            cmd.op   = ccdq_pkg::OP_HCHK;
            cnt_in   = 6'd0;
            state_in = sts.need_div ? S_HDIV : S_TM;
         end
         S_HDIV: begin
            cmd.op = ccdq_pkg::OP_HDIV;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ccdq_pkg::HDivSteps - 1)) begin
               state_in = S_TM;
            end
         end
         S_TM: begin
            cmd.op   = ccdq_pkg::OP_MUL_T;
            state_in = S_TV;
         end
         S_TV: begin
            cmd.op = ccdq_pkg::OP_VSET;
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = S_VM;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_TM;
            end
         end
         S_VM: begin
            cmd.op   = ccdq_pkg::OP_MUL_V;
            state_in = S_VA;
         end
         S_VA: begin
            cmd.op = ccdq_pkg::OP_ACC_VV;
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = S_SQI;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_VM;
            end
         end
         S_SQI: begin
            cmd.op   = ccdq_pkg::OP_SQ_INIT;
            cnt_in   = 6'd0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = ccdq_pkg::OP_SQ_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ccdq_pkg::SqrtSteps - 1)) begin
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            cmd.op   = ccdq_pkg::OP_DIST;
            sel_in   = 2'd0;
            state_in = S_GI;
         end
         S_GI: begin
            cmd.op   = ccdq_pkg::OP_G_INIT;
            cnt_in   = 6'd0;
            state_in = S_GD;
         end
         S_GD: begin
            cmd.op = ccdq_pkg::OP_G_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ccdq_pkg::GDivSteps - 1)) begin
               state_in = S_GS;
            end
         end
         S_GS: begin
            cmd.op = ccdq_pkg::OP_G_SET;
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = S_CMP;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_GI;
            end
         end
         S_CMP: begin
            cmd.op   = ccdq_pkg::OP_CMP;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            // The search ends as soon as the best distance has gone negative.
            if (sts.best_neg) begin
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 7'd1;
               state_in = S_SEG;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         grp_ff   <= ccdq_pkg::GRP_DONE;
         idx_ff   <= 7'd0;
         sel_ff   <= 2'd0;
         cnt_ff   <= 6'd0;
         only_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         idx_ff   <= idx_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
         only_ff  <= only_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

FILE: rtl/core/ccdq_datapath.sv
// Datapath of the capsule chain distance query: node store, one shared multiplier,
// bit-serial divider and square root units and the best-candidate registers.
// Depends on ccdq_pkg.
module ccdq_datapath (
   input  logic              clock,
   input  ccdq_pkg::cmd_type cmd,
   input  ccdq_pkg::req_type req,
   input  ccdq_pkg::cfg_type cfg,
   output ccdq_pkg::sts_type sts,
   output ccdq_pkg::rsp_type rsp
);

   logic [95:0]        node_mem_ff [ccdq_pkg::MaxNodes];
   logic [95:0]        rd_ff;
   logic [95:0]        a_ff;
   logic signed [31:0] p_ff  [3];
   logic signed [32:0] pa_ff [3];
   logic signed [32:0] ba_ff [3];
   logic signed [34:0] v_ff  [3];
   logic signed [69:0] prod_ff;
   logic signed [67:0] dot_ff;
   logic signed [67:0] len_ff;
   logic [67:0]        hrem_ff;
   logic [16:0]        h_ff;
   logic [71:0]        vv_ff;
   logic [71:0]        vsh_ff;
   logic [37:0]        srem_ff;
   logic [35:0]        root_ff;
   logic signed [31:0] dist_ff;
   logic [51:0]        grem_ff;
   logic [51:0]        gden_ff;
   logic [15:0]        gq_ff;
   logic signed [15:0] g_ff [3];
   logic signed [31:0] best_dist_ff;
   logic signed [15:0] best_g_ff [3];
   logic [5:0]         best_node_ff;
   logic [16:0]        best_h_ff;

   logic signed [34:0] mul_a;
   logic signed [34:0] mul_b;
   logic               need_div;
   logic [67:0]        hd_shift;
   logic [69:0]        t_mag;
   logic [69:0]        t_rnd;
   logic signed [34:0] r_signed;
   logic [37:0]        sq_rem;
   logic [37:0]        sq_trial;
   logic [30:0]        radius;
   logic signed [37:0] dd;
   logic [34:0]        v_mag;
   logic [31:0]        a_coord [3];
   logic [31:0]        b_coord [3];

   always_comb begin
      a_coord[0] = a_ff[95:64];
      a_coord[1] = a_ff[63:32];
      a_coord[2] = a_ff[31:0];
      b_coord[0] = rd_ff[95:64];
      b_coord[1] = rd_ff[63:32];
      b_coord[2] = rd_ff[31:0];

      case (cmd.op)
         ccdq_pkg::OP_MUL_DOT: begin
            mul_a = 35'(pa_ff[cmd.sel]);
            mul_b = 35'(ba_ff[cmd.sel]);
         end
         ccdq_pkg::OP_MUL_LEN: begin
            mul_a = 35'(ba_ff[cmd.sel]);
            mul_b = 35'(ba_ff[cmd.sel]);
         end
         ccdq_pkg::OP_MUL_T: begin
            mul_a = 35'(ba_ff[cmd.sel]);
            mul_b = $signed({18'd0, h_ff});
         end
         default: begin
            mul_a = v_ff[cmd.sel];
            mul_b = v_ff[cmd.sel];
         end
      endcase

      // The interpolation factor needs the long division only strictly inside (0, 1).
      need_div = (dot_ff > 68'sd0) && (len_ff != 68'sd0) && (dot_ff < len_ff);
      hd_shift = {hrem_ff[66:0], 1'b0};

      t_mag    = prod_ff[69] ? 70'(-prod_ff) : 70'(prod_ff);
      t_rnd    = t_mag + 70'd32768;
      r_signed = prod_ff[69] ? -$signed(t_rnd[50:16]) : $signed(t_rnd[50:16]);

      sq_rem   = {srem_ff[35:0], vsh_ff[71:70]};
      sq_trial = {root_ff, 2'b01};

      unique case (cmd.grp)
         ccdq_pkg::GRP_TOOL:  radius = cfg.tool_radius;
         ccdq_pkg::GRP_INNER: radius = cfg.inner_radius;
         default:             radius = cfg.outer_radius;
      endcase
      dd = $signed({2'b00, root_ff}) - $signed({7'd0, radius});

      v_mag = v_ff[cmd.sel][34] ? 35'(-v_ff[cmd.sel]) : 35'(v_ff[cmd.sel]);
   end

   // Node store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.op == ccdq_pkg::OP_WRITE) begin
         node_mem_ff[req.write_slot] <= {req.coord_x, req.coord_y, req.coord_z};
      end
      if (cmd.op == ccdq_pkg::OP_READ) begin
         rd_ff <= node_mem_ff[cmd.addr];
         a_ff  <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ccdq_pkg::OP_START: begin
            p_ff[0]      <= req.coord_x;
            p_ff[1]      <= req.coord_y;
            p_ff[2]      <= req.coord_z;
            best_dist_ff <= 32'sh7fffffff;
            best_g_ff[0] <= 16'sd0;
            best_g_ff[1] <= 16'sd0;
            best_g_ff[2] <= 16'sd0;
            best_node_ff <= 6'd0;
            best_h_ff    <= 17'd0;
         end
         ccdq_pkg::OP_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               pa_ff[i] <= 33'(p_ff[i]) - 33'($signed(a_coord[i]));
               ba_ff[i] <= 33'($signed(b_coord[i])) - 33'($signed(a_coord[i]));
            end
            dot_ff <= 68'sd0;
            len_ff <= 68'sd0;
            vv_ff  <= 72'd0;
         end
         ccdq_pkg::OP_MUL_DOT, ccdq_pkg::OP_MUL_LEN, ccdq_pkg::OP_MUL_T,
         ccdq_pkg::OP_MUL_V: begin
            prod_ff <= mul_a * mul_b;
         end
         ccdq_pkg::OP_ACC_DOT: dot_ff <= dot_ff + prod_ff[67:0];
         ccdq_pkg::OP_ACC_LEN: len_ff <= len_ff + prod_ff[67:0];
         ccdq_pkg::OP_HCHK: begin
            h_ff    <= (dot_ff > 68'sd0 && len_ff != 68'sd0 && !need_div) ? 17'h10000 : 17'd0;
            hrem_ff <= dot_ff;
         end
         ccdq_pkg::OP_HDIV: begin
            if (hd_shift >= len_ff) begin
               hrem_ff <= hd_shift - len_ff;
               h_ff    <= {h_ff[15:0], 1'b1};
            end else begin
               hrem_ff <= hd_shift;
               h_ff    <= {h_ff[15:0], 1'b0};
            end
         end
         ccdq_pkg::OP_VSET:   v_ff[cmd.sel] <= 35'(pa_ff[cmd.sel]) - r_signed;
         ccdq_pkg::OP_ACC_VV: vv_ff <= vv_ff + {2'b00, prod_ff};
         ccdq_pkg::OP_SQ_INIT: begin
            vsh_ff  <= vv_ff;
            srem_ff <= 38'd0;
            root_ff <= 36'd0;
         end
         ccdq_pkg::OP_SQ_STEP: begin
            // Two radicand bits per step, one root bit per step.
            if (sq_rem >= sq_trial) begin
               srem_ff <= sq_rem - sq_trial;
               root_ff <= {root_ff[34:0], 1'b1};
            end else begin
               srem_ff <= sq_rem;
               root_ff <= {root_ff[34:0], 1'b0};
            end
            vsh_ff <= {vsh_ff[69:0], 2'b00};
         end
         ccdq_pkg::OP_DIST: begin
            dist_ff <= (dd > 38'sd2147483647) ? 32'sh7fffffff : dd[31:0];
         end
         ccdq_pkg::OP_G_INIT: begin
            // Rounded quotient as floor((2|v| * 16384 + n) / 2n).
            grem_ff <= {3'd0, v_mag[33:0], 15'd0} + {16'd0, root_ff};
            gden_ff <= {root_ff, 16'd0};
            gq_ff   <= 16'd0;
         end
         ccdq_pkg::OP_G_STEP: begin
            if (grem_ff >= gden_ff) begin
               grem_ff <= grem_ff - gden_ff;
               gq_ff   <= {gq_ff[14:0], 1'b1};
            end else begin
               gq_ff   <= {gq_ff[14:0], 1'b0};
            end
            gden_ff <= {1'b0, gden_ff[51:1]};
         end
         ccdq_pkg::OP_G_SET: begin
            if (root_ff == 36'd0) begin
               g_ff[cmd.sel] <= 16'sd0;
            end else if (v_ff[cmd.sel][34]) begin
               g_ff[cmd.sel] <= -$signed(gq_ff);
            end else begin
               g_ff[cmd.sel] <= $signed(gq_ff);
            end
         end
         ccdq_pkg::OP_CMP: begin
            if (dist_ff < best_dist_ff) begin
               best_dist_ff <= dist_ff;
               best_g_ff[0] <= g_ff[0];
               best_g_ff[1] <= g_ff[1];
               best_g_ff[2] <= g_ff[2];
               best_node_ff <= cmd.addr;
               best_h_ff    <= h_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign sts.need_div = need_div;
   assign sts.best_neg = best_dist_ff[31];

   assign rsp.distance     = best_dist_ff;
   assign rsp.grad_x       = best_g_ff[0];
   assign rsp.grad_y       = best_g_ff[1];
   assign rsp.grad_z       = best_g_ff[2];
   assign rsp.nearest_node = best_node_ff;
   assign rsp.seg_fraction = best_h_ff;

endmodule

FILE: rtl/core/ccdq_checker.sv
// Port-level checks of the capsule chain distance query, bound to the top level.
// Depends on ccdq_pkg and capsule_chain_distance_query.
module ccdq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input ccdq_pkg::req_type req_payload,
   input logic              busy,
   input logic              rsp_valid,
   input ccdq_pkg::rsp_type rsp_payload
);

   // A query transaction always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.opcode == ccdq_pkg::OPC_QUERY) |=> busy)
      else $error("query transaction did not raise busy");

   // A node write completes at once and never occupies the block.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.opcode == ccdq_pkg::OPC_WRITE) |=> !busy)
      else $error("node write left the block busy");

   // A result is shown while busy and ends the query in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 (!busy && !rsp_valid))
      else $error("result strobe not followed by idle");

   // The interpolation factor never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.seg_fraction <= 17'h10000))
      else $error("interpolation factor above one");

endmodule

bind capsule_chain_distance_query ccdq_checker u_ccdq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .req_payload (req_payload),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

FILE: tb/testbench.sv
// Self-checking testbench for capsule_chain_distance_query: a node-write and
// query transaction stream checked against a built-in capsule distance predictor.
// Depends on ccdq_pkg and the capsule_chain_distance_query RTL.
module testbench;

   localparam int CycleLimit = 12000000;

   class distance_scoreboard;
      longint              node_pos[ccdq_pkg::MaxNodes][3];
      int unsigned         node_cnt[3];      // outer, inner, tool
      bit                  tool_on;
      longint              tube_rad[3];
      ccdq_pkg::rsp_type   pending[$];
      int                  mismatches;
      int                  results_seen;
      int                  queries;
      int                  writes;
      longint              best_dist;
      longint              best_grad[3];
      int unsigned         best_node;
      longint              best_h;

      function void set_reg(logic [2:0] idx, logic [30:0] val);
         case (idx)
            ccdq_pkg::CSR_OUTER_COUNT: node_cnt[0] = val[6:0];
            ccdq_pkg::CSR_INNER_COUNT: node_cnt[1] = val[6:0];
            ccdq_pkg::CSR_TOOL_COUNT:  node_cnt[2] = val[6:0];
            ccdq_pkg::CSR_TOOL_PRES:   tool_on = val[0];
            ccdq_pkg::CSR_OUTER_RAD:   tube_rad[0] = val;
            ccdq_pkg::CSR_INNER_RAD:   tube_rad[1] = val;
            ccdq_pkg::CSR_TOOL_RAD:    tube_rad[2] = val;
            default: ;
         endcase
      endfunction

      function void capsule(longint p[3], int unsigned ia, longint radius,
                            output longint seg_dist, output longint g[3],
                            output longint h);
         longint pa[3], ba[3], v[3];
         logic signed [127:0] dot, a128, b128;
         logic [127:0] len2, vv, c, du;
         longint t, r, n, dd, num, q;
         dot = 0;
         len2 = 0;
         vv = 0;
         h = 0;
         n = 0;
         for (int i = 0; i < 3; i++) begin
            pa[i] = p[i] - node_pos[ia][i];
            ba[i] = node_pos[ia+1][i] - node_pos[ia][i];
            a128 = pa[i];
            b128 = ba[i];
            dot += a128 * b128;
            len2 += b128 * b128;
         end
         if (len2 != 0 && dot > 0) begin
            du = dot;
            if (du >= len2) h = 65536;
            else h = longint'((du << 16) / len2);
         end
         for (int i = 0; i < 3; i++) begin
            t = ba[i] * h;
            r = ((t < 0 ? -t : t) + 32768) >>> 16;
            v[i] = pa[i] - (t < 0 ? -r : r);
            a128 = v[i];
            vv += a128 * a128;
         end
         for (int i = 35; i >= 0; i--) begin
            c = n | (128'(1) << i);
            if (vv >= c * c) n = longint'(c);
         end
         dd = n - radius;
         seg_dist = dd > 64'sd2147483647 ? 64'sd2147483647 : dd;
         for (int i = 0; i < 3; i++) begin
            if (n == 0) begin
               g[i] = 0;
            end else begin
               num = v[i] * 16384;
               q = ((num < 0 ? -num : num) * 2 + n) / (2 * n);
               g[i] = num < 0 ? -q : q;
            end
         end
      endfunction

      // Returns 1 once the best distance has gone negative.
      function bit search_tube(longint p[3], int unsigned base, int unsigned count,
                               longint radius);
         longint d, g[3], h;
         for (int unsigned i = 0; i + 1 < count; i++) begin
            if (base + i + 1 >= ccdq_pkg::MaxNodes) break;
            capsule(p, base + i, radius, d, g, h);
            if (d < best_dist) begin
               best_dist = d;
               best_grad = g;
               best_node = base + i;
               best_h = h;
            end
            if (best_dist < 0) return 1;
         end
         return 0;
      endfunction

      function void note(ccdq_pkg::req_type r);
         longint p[3];
         bit done;
         ccdq_pkg::rsp_type e;
         p[0] = r.coord_x;
         p[1] = r.coord_y;
         p[2] = r.coord_z;
         if (r.opcode == ccdq_pkg::OPC_WRITE) begin
            writes++;
            node_pos[r.write_slot] = p;
            return;
         end
         queries++;
         best_dist = 64'sd2147483647;
         best_grad = '{0, 0, 0};
         best_node = 0;
         best_h = 0;
         done = 0;
         if (tool_on)
            done = search_tube(p, node_cnt[0] + node_cnt[1], node_cnt[2], tube_rad[2]);
         if (!done && !r.tool_search_only) begin
            done = search_tube(p, node_cnt[0], node_cnt[1], tube_rad[1]);
            if (!done) done = search_tube(p, 0, node_cnt[0], tube_rad[0]);
         end
         e.distance = best_dist[31:0];
         e.grad_x = best_grad[0][15:0];
         e.grad_y = best_grad[1][15:0];
         e.grad_z = best_grad[2][15:0];
         e.nearest_node = best_node[5:0];
         e.seg_fraction = best_h[16:0];
         pending.push_back(e);
      endfunction

      function void check(ccdq_pkg::rsp_type got);
         ccdq_pkg::rsp_type e;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result transaction: dist %0d node %0d",
                        got.distance, got.nearest_node);
            return;
         end
         e = pending.pop_front();
         if (got.distance !== e.distance || got.grad_x !== e.grad_x ||
             got.grad_y !== e.grad_y || got.grad_z !== e.grad_z ||
             got.nearest_node !== e.nearest_node ||
             got.seg_fraction !== e.seg_fraction) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch on result %0d:", results_seen);
               $display("  expected dist %0d grad %0d %0d %0d node %0d h %0d",
                        e.distance, e.grad_x, e.grad_y, e.grad_z,
                        e.nearest_node, e.seg_fraction);
               $display("  actual   dist %0d grad %0d %0d %0d node %0d h %0d",
                        got.distance, got.grad_x, got.grad_y, got.grad_z,
                        got.nearest_node, got.seg_fraction);
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   ccdq_pkg::req_type req_payload;
   logic              busy;
   logic              rsp_valid;
   ccdq_pkg::rsp_type rsp_payload;
   logic              csr_we;
   logic [2:0]        csr_index;
   logic [30:0]       csr_wdata;

   distance_scoreboard sb;
   int  cycles = 0;
   bit  quiet;

   capsule_chain_distance_query uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_payload(req_payload),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Both handshakes are sampled before the edge takes effect.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note(req_payload);
         if (rsp_valid) sb.check(rsp_payload);
      end
   end

   function automatic logic signed [31:0] pick_coord(bit full);
      if (full) return $urandom;
      return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
   endfunction

   task automatic send(ccdq_pkg::req_type r);
      if (!quiet) begin
         while ($urandom_range(99) < 34) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1;
      req_payload <= r;
      do @(posedge clock); while (!(start && !busy));
   endtask

   task automatic send_node(int slot, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
      ccdq_pkg::req_type r;
      r = '0;
      r.opcode = ccdq_pkg::OPC_WRITE;
      r.write_slot = 6'(slot);
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.tool_search_only = 1'($urandom_range(1));
      send(r);
   endtask

   task automatic send_query(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, bit tool_only);
      ccdq_pkg::req_type r;
      r = '0;
      r.opcode = ccdq_pkg::OPC_QUERY;
      r.write_slot = 6'($urandom);
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.tool_search_only = tool_only;
      send(r);
   endtask

   // Drains all outstanding queries, then programs every register.
   task automatic configure(int oc, int ic, int tc, bit tp, logic [30:0] orad,
                            logic [30:0] irad, logic [30:0] trad);
      logic [30:0] vals[7];
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      vals = '{31'(oc), 31'(ic), 31'(tc), 31'(tp), orad, irad, trad};
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(3'(i), vals[i]);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic [30:0] pick_radius();
      case ($urandom_range(3))
         0: return 31'd0;
         1: return 31'h7fffffff;
         default: return 31'($urandom_range(0, 1 << 17));
      endcase
   endfunction

   initial begin
      bit tc;
      bit huge;
      sb = new;
      quiet = 0;
      reset = 1;
      start = 0;
      req_payload = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Every slot is written before any query reads it; slot 1 repeats slot 0
      // so that the first segment has zero length.
      send_node(0, 32'sd65536, 32'sd0, 32'sd0);
      send_node(1, 32'sd65536, 32'sd0, 32'sd0);
      send_node(63, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      for (int s = 2; s < 63; s++)
         send_node(s, pick_coord(1'b0), pick_coord(1'b0), pick_coord(1'b0));

      // Directed part: an out-of-range register index, tiny groups and extremes.
      configure(3, 3, 3, 1'b1, 31'd0, 31'h7fffffff, 31'd65536);
      csr_we <= 1;
      csr_index <= 3'd7;
      csr_wdata <= 31'h7fffffff;
      @(posedge clock);
      csr_we <= 0;
      send_query(32'sd65536, 32'sd0, 32'sd0, 1'b0);
      send_query(32'sd65536, 32'sd0, 32'sd0, 1'b1);
      send_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
      send_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
      configure(2, 1, 0, 1'b0, 31'd0, 31'd0, 31'd0);
      send_query(32'sd65536, 32'sd0, 32'sd0, 1'b0);
      send_query(32'sd0, 32'sd131072, 32'sh80000000, 1'b0);
      configure(1, 1, 1, 1'b1, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      send_query(32'sd0, 32'sd0, 32'sd0, 1'b0);
      configure(0, 0, 0, 1'b0, 31'd0, 31'd0, 31'd0);
      send_query(32'sd5, 32'sd7, 32'sd9, 1'b0);

      // Random phases; one runs without any idling and one uses the largest
      // node counts, where only the outer group fits in the store.
      for (int ph = 0; ph < 10; ph++) begin
         huge = (ph == 4);
         quiet = (ph == 6);
         if (huge)
            configure(64, 64, 64, 1'b1, 31'd0, 31'd0, 31'd0);
         else
            configure($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                      1'($urandom_range(1)), pick_radius(), pick_radius(), pick_radius());
         for (int k = 0; k < 52; k++) begin
            if ((huge ? $urandom_range(5) == 0 : $urandom_range(1) == 1)) begin
               tc = ($urandom_range(4) == 0);
               send_query(pick_coord(tc), pick_coord(tc), pick_coord(tc),
                          $urandom_range(3) == 0);
            end else begin
               tc = ($urandom_range(4) == 0);
               send_node($urandom_range(0, 63), pick_coord(tc), pick_coord(tc),
                         pick_coord(tc));
            end
         end
      end
      quiet = 0;

      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d node writes and %0d distance queries over 14 settings,",
               sb.writes, sb.queries);
      $display("%0d results checked, %0d mismatches.", sb.results_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ccdq_pkg.sv
rtl/core/ccdq_ctrl.sv
rtl/core/ccdq_datapath.sv
rtl/core/capsule_chain_distance_query.sv
rtl/core/ccdq_checker.sv
tb/testbench.sv
